// ----- hdl/cllc_pkg.sv -----
package cllc_pkg;

    localparam int MAX_GROUPS_DEF = 64;

    localparam int RADIUS_W = 24;
    localparam int CAP_W    = 12;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W  = 32;
    localparam int DIST_W   = 49;
    localparam int RSQ_W    = 48;
    localparam int NUM_W    = 46;
    localparam int GIDX_W   = 6;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd62915;
    localparam logic [CAP_W-1:0]    CAP_RST    = 12'd15;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_CAPACITY = 1'd1;

    localparam logic [1:0] ST_JOINED   = 2'd0;
    localparam logic [1:0] ST_OPENED   = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_lat;
        logic signed [COORD_W-1:0] point_lng;
        logic [WEIGHT_W-1:0]       point_weight;
    } pt_word_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [GIDX_W-1:0]         group_index;
        logic [CAP_W-1:0]          member_count;
        logic signed [COORD_W-1:0] centroid_lat;
        logic signed [COORD_W-1:0] centroid_lng;
        logic [TOTAL_W-1:0]        weight_total;
    } res_word_t;

    // point plus best match so far, marching down the cell row
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] lat;
        logic signed [COORD_W-1:0] lng;
        logic [WEIGHT_W-1:0]       w;
        logic                      found;
        logic [DIST_W-1:0]         best_d;
        logic signed [COORD_W-1:0] blat;
        logic signed [COORD_W-1:0] blng;
        logic [CAP_W-1:0]          bcnt;
        logic [TOTAL_W-1:0]        bwt;
    } cllc_tok_t;

    typedef struct packed {
        logic                      we;
        logic signed [COORD_W-1:0] lat;
        logic signed [COORD_W-1:0] lng;
        logic [CAP_W-1:0]          cnt;
        logic [TOTAL_W-1:0]        wt;
    } cllc_upd_t;

endpackage

// ----- hdl/cllc_pt_if.sv -----
interface cllc_pt_if
    import cllc_pkg::*;
();
    logic     valid;
    logic     ready;
    pt_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/cllc_res_if.sv -----
interface cllc_res_if
    import cllc_pkg::*;
();
    logic      valid;
    logic      ready;
    res_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/cllc_div.sv -----
module cllc_div
    import cllc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [CAP_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CAP_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [CAP_W-1:0] den_reg, den_next;
    logic [CAP_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring
            rem_next = fits ? CAP_W'(trial - {1'b0, den_reg}) : CAP_W'(trial);
            q_next   = {q_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

// ----- hdl/cllc_cell.sv -----
module cllc_cell
    import cllc_pkg::*;
#(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF,
    parameter int G = 0,
    parameter int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
    parameter int GW = $clog2(MAX_GROUPS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cllc_tok_t           tok_in,
    input  logic [IW-1:0]       idx_in,
    output cllc_tok_t           tok_out,
    output logic [IW-1:0]       idx_out,
    input  logic [RADIUS_W-1:0] radius,
    input  logic [RSQ_W-1:0]    radius_sq,
    input  logic [CAP_W-1:0]    cap,
    input  logic [GW-1:0]       groups_open,
    input  cllc_upd_t           upd,
    input  logic [IW-1:0]       upd_idx
);
    logic signed [COORD_W-1:0] lat_reg;
    logic signed [COORD_W-1:0] lng_reg;
    logic [CAP_W-1:0]          cnt_reg;
    logic [TOTAL_W-1:0]        wt_reg;

    cllc_tok_t          mid_reg, mid_next;
    logic [IW-1:0]      mid_idx_reg;
    logic [RSQ_W-1:0]   sql_reg, sql_next, sqg_reg, sqg_next;
    logic               qual_reg, qual_next;
    cllc_tok_t          out_reg, out_next;
    logic [IW-1:0]      out_idx_reg, out_idx_next;

    logic signed [COORD_W:0] dlat_s, dlng_s;
    logic [COORD_W:0]        dlat, dlng;
    logic [DIST_W-1:0]       d2;
    logic                    take;

    always_ff @(posedge clk)
    begin
        if (upd.we && upd_idx == IW'(G))
        begin
            lat_reg <= upd.lat;
            lng_reg <= upd.lng;
            cnt_reg <= upd.cnt;
            wt_reg  <= upd.wt;
        end
    end

    // first half: axis offsets, their squares and the qualify check
    always_comb
    begin
        dlat_s    = {tok_in.lat[COORD_W-1], tok_in.lat} - {lat_reg[COORD_W-1], lat_reg};
        dlng_s    = {tok_in.lng[COORD_W-1], tok_in.lng} - {lng_reg[COORD_W-1], lng_reg};
        dlat      = dlat_s[COORD_W] ? (COORD_W+1)'(-dlat_s) : dlat_s;
        dlng      = dlng_s[COORD_W] ? (COORD_W+1)'(-dlng_s) : dlng_s;
        qual_next = (GW'(G) < groups_open) && (cnt_reg < cap)
                    && (dlat <= (COORD_W+1)'(radius)) && (dlng <= (COORD_W+1)'(radius));
        sql_next  = dlat[RADIUS_W-1:0] * dlat[RADIUS_W-1:0];
        sqg_next  = dlng[RADIUS_W-1:0] * dlng[RADIUS_W-1:0];
        mid_next  = tok_in;
    end

    // second half: compare with best so far, strict less keeps the earlier group
    always_comb
    begin
        d2           = {1'b0, sql_reg} + {1'b0, sqg_reg};
        take         = qual_reg && (d2 <= {1'b0, radius_sq})
                       && (!mid_reg.found || d2 < mid_reg.best_d);
        out_next     = mid_reg;
        out_idx_next = mid_idx_reg;
        if (take)
        begin
            out_next.found  = 1'b1;
            out_next.best_d = d2;
            out_next.blat   = lat_reg;
            out_next.blng   = lng_reg;
            out_next.bcnt   = cnt_reg;
            out_next.bwt    = wt_reg;
            out_idx_next    = IW'(G);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            mid_reg <= mid_next;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_idx_reg <= idx_in;
        sql_reg     <= sql_next;
        sqg_reg     <= sqg_next;
        qual_reg    <= qual_next;
        out_idx_reg <= out_idx_next;
    end

    assign tok_out = out_reg;
    assign idx_out = out_idx_reg;
endmodule

// ----- hdl/capacity_limited_leader_clustering.sv -----
// Channel   Role    Word                                         Handshake
// point     sink    point_lat, point_lng, point_weight           valid/ready
// result    source  status, group_index, member_count,           valid/ready
//                   centroid_lat, centroid_lng, weight_total
// cfg       write   cfg_index selects register, cfg_data         cfg_we
//
// One point at a time. The point walks the row of group cells, registered in
// each cell's mid and out registers; opening a group or rejecting goes straight
// to the output state, while joining first passes the multiply and sum states
// and the 46-step dividers of the mean update. Groups hold no reset; only the open count clears.
// The result register frees the input while a result waits on a stalled sink.
module capacity_limited_leader_clustering
    import cllc_pkg::*;
#(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    cllc_pt_if.sink              point,
    cllc_res_if.source           result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GW = $clog2(MAX_GROUPS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_MUL  = 6'b000100,
        S_SUM  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [RADIUS_W-1:0] radius_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [RSQ_W-1:0]    rsq_reg;
    logic [GW-1:0]       open_reg, open_next;

    cllc_tok_t     tok [MAX_GROUPS+1];
    logic [IW-1:0] tidx [MAX_GROUPS+1];
    cllc_tok_t     launch_reg, launch_next;

    cllc_upd_t     upd_reg, upd_next;
    logic [IW-1:0] upd_idx_reg, upd_idx_next;

    logic signed [COORD_W-1:0] p_lat_reg, p_lng_reg;
    logic signed [COORD_W-1:0] b_lat_reg, b_lng_reg;
    logic [IW-1:0]             b_idx_reg;
    logic [CAP_W-1:0]          m_reg;
    logic [TOTAL_W-1:0]        wt_reg;
    logic signed [44:0]        prod_lat_reg, prod_lng_reg;
    logic                      neg_lat_reg, neg_lng_reg;

    res_word_t pend_reg, pend_next;
    res_word_t out_reg;
    logic      out_valid_reg;

    logic [CAP_W-1:0]        m_calc;
    logic [TOTAL_W:0]        wsum;
    logic signed [NUM_W-1:0] num_lat, num_lng;
    logic [NUM_W-1:0]        mag_lat, mag_lng;
    logic                    div_start, div_done, div_done_lng;
    logic [NUM_W-1:0]        q_lat, q_lng;
    logic signed [COORD_W-1:0] c_lat, c_lng;
    logic                    out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            cap_reg    <= CAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_RADIUS:     radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_GROUP_CAPACITY: cap_reg    <= cfg_data[CAP_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rsq_reg <= radius_reg * radius_reg;
    end

    assign tok[0]  = launch_reg;
    assign tidx[0] = '0;

    for (genvar g = 0; g < MAX_GROUPS; g++)
    begin : g_cell
        cllc_cell #(
            .MAX_GROUPS (MAX_GROUPS),
            .G          (g),
            .IW         (IW),
            .GW         (GW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .tok_in      (tok[g]),
            .idx_in      (tidx[g]),
            .tok_out     (tok[g+1]),
            .idx_out     (tidx[g+1]),
            .radius      (radius_reg),
            .radius_sq   (rsq_reg),
            .cap         (cap_reg),
            .groups_open (open_reg),
            .upd         (upd_reg),
            .upd_idx     (upd_idx_reg)
        );
    end

    assign num_lat = {prod_lat_reg[44], prod_lat_reg} + NUM_W'(p_lat_reg);
    assign num_lng = {prod_lng_reg[44], prod_lng_reg} + NUM_W'(p_lng_reg);
    assign mag_lat = num_lat[NUM_W-1] ? NUM_W'(-num_lat) : num_lat;
    assign mag_lng = num_lng[NUM_W-1] ? NUM_W'(-num_lng) : num_lng;
    assign div_start = (state_reg == S_SUM);

    cllc_div u_div_lat (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mag_lat),
        .den   (m_reg),
        .done  (div_done),
        .quo   (q_lat)
    );

    cllc_div u_div_lng (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mag_lng),
        .den   (m_reg),
        .done  (div_done_lng),
        .quo   (q_lng)
    );

    assign c_lat = neg_lat_reg ? COORD_W'(-q_lat[COORD_W-1:0]) : q_lat[COORD_W-1:0];
    assign c_lng = neg_lng_reg ? COORD_W'(-q_lng[COORD_W-1:0]) : q_lng[COORD_W-1:0];

    assign m_calc = (tok[MAX_GROUPS].bcnt + 1'b1 == '0) ? '1 : tok[MAX_GROUPS].bcnt + 1'b1;
    assign wsum   = {1'b0, tok[MAX_GROUPS].bwt} + (TOTAL_W+1)'(tok[MAX_GROUPS].w);
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next   = state_reg;
        open_next    = open_reg;
        launch_next  = launch_reg;
        launch_next.valid = 1'b0;
        upd_next     = upd_reg;
        upd_next.we  = 1'b0;
        upd_idx_next = upd_idx_reg;
        pend_next    = pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (point.valid)
                begin
                    launch_next        = '0;
                    launch_next.valid  = 1'b1;
                    launch_next.lat    = point.data.point_lat;
                    launch_next.lng    = point.data.point_lng;
                    launch_next.w      = point.data.point_weight;
                    state_next         = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok[MAX_GROUPS].valid)
                begin
                    if (tok[MAX_GROUPS].found)
                    begin
                        state_next = S_MUL;
                    end
                    else if (open_reg < GW'(MAX_GROUPS))
                    begin
                        upd_next.we  = 1'b1;
                        upd_next.lat = tok[MAX_GROUPS].lat;
                        upd_next.lng = tok[MAX_GROUPS].lng;
                        upd_next.cnt = CAP_W'(1);
                        upd_next.wt  = TOTAL_W'(tok[MAX_GROUPS].w);
                        upd_idx_next = IW'(open_reg);
                        open_next    = open_reg + 1'b1;
                        pend_next.status       = ST_OPENED;
                        pend_next.group_index  = GIDX_W'(open_reg);
                        pend_next.member_count = CAP_W'(1);
                        pend_next.centroid_lat = tok[MAX_GROUPS].lat;
                        pend_next.centroid_lng = tok[MAX_GROUPS].lng;
                        pend_next.weight_total = TOTAL_W'(tok[MAX_GROUPS].w);
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        pend_next        = '0;
                        pend_next.status = ST_REJECTED;
                        state_next       = S_OUT;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done && div_done_lng)
                begin
                    upd_next.we  = 1'b1;
                    upd_next.lat = c_lat;
                    upd_next.lng = c_lng;
                    upd_next.cnt = m_reg;
                    upd_next.wt  = wt_reg;
                    upd_idx_next = b_idx_reg;
                    pend_next.status       = ST_JOINED;
                    pend_next.group_index  = GIDX_W'(b_idx_reg);
                    pend_next.member_count = m_reg;
                    pend_next.centroid_lat = c_lat;
                    pend_next.centroid_lng = c_lng;
                    pend_next.weight_total = wt_reg;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            open_reg      <= '0;
            launch_reg    <= '0;
            upd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            open_reg   <= open_next;
            launch_reg <= launch_next;
            upd_reg    <= upd_next;
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        upd_idx_reg <= upd_idx_next;
        pend_reg    <= pend_next;
        if (state_reg == S_OUT && out_free)
        begin
            out_reg <= pend_reg;
        end
        if (state_reg == S_SCAN && tok[MAX_GROUPS].valid)
        begin
            // hold the winner for the mean update
            p_lat_reg <= tok[MAX_GROUPS].lat;
            p_lng_reg <= tok[MAX_GROUPS].lng;
            b_lat_reg <= tok[MAX_GROUPS].blat;
            b_lng_reg <= tok[MAX_GROUPS].blng;
            b_idx_reg <= tidx[MAX_GROUPS];
            m_reg     <= m_calc;
            wt_reg    <= wsum[TOTAL_W] ? '1 : wsum[TOTAL_W-1:0];
        end
        if (state_reg == S_MUL)
        begin
            prod_lat_reg <= $signed(b_lat_reg) * $signed({1'b0, CAP_W'(m_reg - 1'b1)});
            prod_lng_reg <= $signed(b_lng_reg) * $signed({1'b0, CAP_W'(m_reg - 1'b1)});
        end
        if (state_reg == S_SUM)
        begin
            neg_lat_reg <= num_lat[NUM_W-1];
            neg_lng_reg <= num_lng[NUM_W-1];
        end
    end

    assign point.ready  = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;
endmodule

// ----- test/cluster_checker.sv -----
`timescale 1ns / 1ps

module cluster_checker
    import cllc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cllc_pt_if                   pt,
    cllc_res_if                  res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fails,
    output int                   pending,
    output int                   joins,
    output int                   opens,
    output int                   rejects
);

    localparam int GROUPS = MAX_GROUPS_DEF;

    logic signed [COORD_W-1:0] cen_lat [GROUPS];
    logic signed [COORD_W-1:0] cen_lng [GROUPS];
    logic [CAP_W-1:0]          members [GROUPS];
    logic [TOTAL_W-1:0]        grams   [GROUPS];
    int                        groups_used;
    logic [RADIUS_W-1:0]       radius;
    logic [CAP_W-1:0]          capacity;
    res_word_t                 expected_assignments [$];

    function automatic logic signed [COORD_W-1:0] running_mean(
        logic signed [COORD_W-1:0] c, logic signed [COORD_W-1:0] p, logic [CAP_W-1:0] m);
        longint mm;
        longint num;
        mm  = longint'(m);
        num = longint'(c) * (mm - 1) + longint'(p);
        return COORD_W'(num / mm);
    endfunction

    // update the group table for one point and return the assignment word
    function automatic res_word_t assign_point(pt_word_t p);
        longint    r;
        longint    dl;
        longint    dg;
        longint    d2;
        longint    best_d;
        longint    s;
        bit        found;
        int        best;
        int        idx;
        logic [CAP_W-1:0] m;
        res_word_t o;
        r = longint'(radius);
        found = 0;
        best = 0;
        best_d = 0;
        o = '0;
        for (int g = 0; g < groups_used; g++)
        begin
            if (members[g] >= capacity)
                continue;
            dl = longint'(p.point_lat) - longint'(cen_lat[g]);
            dg = longint'(p.point_lng) - longint'(cen_lng[g]);
            if (dl < 0)
                dl = -dl;
            if (dg < 0)
                dg = -dg;
            if (dl > r || dg > r)
                continue;
            d2 = dl * dl + dg * dg;
            if (d2 <= r * r && (!found || d2 < best_d))
            begin
                found = 1;
                best = g;
                best_d = d2;
            end
        end
        if (found)
        begin
            m = members[best] + 1'b1;
            if (m == 0)
                m = '1;
            s = longint'(grams[best]) + longint'(p.point_weight);
            members[best] = m;
            grams[best] = (s > 64'hFFFF_FFFF) ? '1 : TOTAL_W'(s);
            cen_lat[best] = running_mean(cen_lat[best], p.point_lat, m);
            cen_lng[best] = running_mean(cen_lng[best], p.point_lng, m);
            o.status = ST_JOINED;
            idx = best;
        end
        else if (groups_used < GROUPS)
        begin
            idx = groups_used;
            cen_lat[idx] = p.point_lat;
            cen_lng[idx] = p.point_lng;
            members[idx] = 1;
            grams[idx] = TOTAL_W'(p.point_weight);
            groups_used++;
            o.status = ST_OPENED;
        end
        else
        begin
            o.status = ST_REJECTED;
            return o;
        end
        o.group_index  = GIDX_W'(idx);
        o.member_count = members[idx];
        o.centroid_lat = cen_lat[idx];
        o.centroid_lng = cen_lng[idx];
        o.weight_total = grams[idx];
        return o;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_word_t e;
        res_word_t r;
        if (!rst_n)
        begin
            groups_used = 0;
            radius = RADIUS_RST;
            capacity = CAP_RST;
            expected_assignments.delete();
            fails = 0;
            pending <= 0;
            joins <= 0;
            opens <= 0;
            rejects <= 0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_MAX_RADIUS)
                radius = cfg_data[RADIUS_W-1:0];
            else if (cfg_we && cfg_index == REG_GROUP_CAPACITY)
                capacity = cfg_data[CAP_W-1:0];
            if (pt.valid && pt.ready)
            begin
                e = assign_point(pt.data);
                expected_assignments = {expected_assignments, e};
                if (e.status == ST_JOINED)
                    joins <= joins + 1;
                else if (e.status == ST_OPENED)
                    opens <= opens + 1;
                else
                    rejects <= rejects + 1;
            end
            if (res.valid && res.ready)
            begin
                r = res.data;
                if (expected_assignments.size() == 0)
                    report("unexpected word", 32'(r.status), 32'hx);
                else
                begin
                    e = expected_assignments.pop_front();
                    if (r.status !== e.status)
                        report("status", 32'(r.status), 32'(e.status));
                    if (r.group_index !== e.group_index)
                        report("group_index", 32'(r.group_index), 32'(e.group_index));
                    if (r.member_count !== e.member_count)
                        report("member_count", 32'(r.member_count), 32'(e.member_count));
                    if (r.centroid_lat !== e.centroid_lat)
                        report("centroid_lat", r.centroid_lat, e.centroid_lat);
                    if (r.centroid_lng !== e.centroid_lng)
                        report("centroid_lng", r.centroid_lng, e.centroid_lng);
                    if (r.weight_total !== e.weight_total)
                        report("weight_total", r.weight_total, e.weight_total);
                end
            end
            pending <= expected_assignments.size();
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import cllc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    bit                   calm;
    int                   fails;
    int                   pending;
    int                   joins;
    int                   opens;
    int                   rejects;
    pt_word_t             recent [$];

    cllc_pt_if  pt_ch ();
    cllc_res_if res_ch ();

    capacity_limited_leader_clustering uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (pt_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cluster_checker chk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt        (pt_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending),
        .joins     (joins),
        .opens     (opens),
        .rejects   (rejects)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // back-pressure on the result side
    always @(posedge clk)
        res_ch.ready <= calm || ($urandom_range(99) >= 36);

    task automatic send_point(logic [31:0] lat, logic [31:0] lng, logic [15:0] w);
        pt_word_t p;
        p.point_lat = lat;
        p.point_lng = lng;
        p.point_weight = w;
        recent = {recent, p};
        if (recent.size() > 40)
            void'(recent.pop_front());
        if (!calm && $urandom_range(99) < 36)
        begin
            pt_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.data <= p;
        @(posedge clk);
        while (!pt_ch.ready)
            @(posedge clk);
    endtask

    // hold until every expected word has come back
    task automatic drain;
        pt_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_config(logic [23:0] radius, logic [11:0] cap);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_MAX_RADIUS;
        cfg_data <= radius;
        @(posedge clk);
        cfg_index <= REG_GROUP_CAPACITY;
        cfg_data <= CFG_W'(cap);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_points(int n, int spread, int calm_first);
        pt_word_t b;
        logic [15:0] w;
        for (int i = 0; i < n; i++)
        begin
            calm = (i < calm_first);
            case ($urandom_range(3))
                0: w = 16'hFFFF;
                1: w = 16'h0000;
                default: w = 16'($urandom_range(65535));
            endcase
            if (recent.size() > 0 && $urandom_range(99) < 75)
            begin
                b = recent[$urandom_range(recent.size() - 1)];
                send_point(b.point_lat + $urandom_range(2 * spread) - spread,
                           b.point_lng + $urandom_range(2 * spread) - spread, w);
            end
            else
                send_point($urandom, $urandom, w);
        end
        calm = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        calm = 0;
        cfg_we <= 1'b0;
        cfg_index <= REG_MAX_RADIUS;
        cfg_data <= '0;
        pt_ch.valid <= 1'b0;
        pt_ch.data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: exact-radius join, coordinate and weight extremes
        send_point(32'd0, 32'd0, 16'd0);
        send_point(32'd62915, 32'd0, 16'hFFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 16'd1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);

        // tie goes to the lower group, capacity fills, single-axis overshoot
        set_config(24'd1000, 12'd3);
        send_point(32'd1_000_000_000, 32'd0, 16'd5);
        send_point(32'd1_000_001_500, 32'd0, 16'd7);
        send_point(32'd1_000_000_750, 32'd0, 16'd9);
        send_point(32'd1_000_000_100, 32'd0, 16'd11);
        send_point(32'd1_000_000_100, 32'd0, 16'd13);
        send_point(32'd1_000_001_500, 32'd1001, 16'd15);
        send_point(32'd1_000_001_400, 32'd0, 16'hFFFE);

        // large radius, roomy groups: mostly joins
        set_config(24'hFF_FFFF, 12'd4095);
        random_points(250, 1 << 23, 100);

        // zero radius, one member each: open until the table is full, then reject
        set_config(24'd0, 12'd1);
        random_points(80, 4, 0);

        set_config(24'hFF_FFFF, 12'd4095);
        random_points(240, 1 << 22, 0);

        set_config(24'($urandom_range(20000, 200000)), 12'($urandom_range(1, 20)));
        random_points(200, 1 << 17, 0);

        drain();
        $display("points sent through reset settings and five register settings:");
        $display("%0d joined, %0d opened groups, %0d rejected", joins, opens, rejects);
        if (fails == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/cllc_pkg.sv
hdl/cllc_pt_if.sv
hdl/cllc_res_if.sv
hdl/cllc_div.sv
hdl/cllc_cell.sv
hdl/capacity_limited_leader_clustering.sv
test/cluster_checker.sv
test/tb.sv
